FILE: design/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int ADDR_W  = 32;
  localparam int REQ_W   = 17;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPTR = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [REQ_W-1:0] HEAP_SIZE_RST = 17'd65536;

  // compare done on each scanned entry
  typedef enum logic [1:0] {
    SK_FIT,    // size >= request
    SK_MATCH,  // base + start == address
    SK_AFTER   // start > key start
  } scan_kind_t;

endpackage
`default_nettype wire

FILE: design/first_fit_heap_allocator_unit.sv
`default_nettype none
// Each item scans its chunk table entry by entry and shifts entries to insert or remove;
//   zero-size allocs and null frees skip the tables and return their result directly.
// Throughput: one item at a time; in_stall stays high until the sequencer is idle again.
// Reset: sync active-low; tables reinit to one free chunk covering the heap,
//   same after any heap_size write.
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request items
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [REQ_W-1:0]  in_request_bytes,
  input  logic [ADDR_W-1:0] in_block_address,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [ADDR_W-1:0] out_result_address,
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int OB = OFFSET_BITS;
  localparam int SW = OB + 1;                     // chunk size width, holds 2^OB
  localparam int EW = (SW > REQ_W) ? SW : REQ_W;  // compare width for sizes vs request
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int TW = OB + SW;                    // table word {start, size}
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  // sequencer states
  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_INIT     = 11'b00000000010,
    S_SCAN_RD  = 11'b00000000100,
    S_SCAN_CHK = 11'b00000001000,
    S_SHUP_RD  = 11'b00000010000,
    S_SHUP_WR  = 11'b00000100000,
    S_SHDN_RD  = 11'b00001000000,
    S_SHDN_WR  = 11'b00010000000,
    S_WRITE    = 11'b00100000000,
    S_NEXT     = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  // step of the current item; S_NEXT dispatches on this
  typedef enum logic [8:0] {
    P_FIT    = 9'b000000001,  // alloc: first free chunk that fits
    P_FUPD   = 9'b000000010,  // alloc: tail rewritten or chunk removed
    P_UPOS   = 9'b000000100,  // alloc: insert slot in used table
    P_UINS   = 9'b000001000,  // alloc: used entry inserted
    P_MATCH  = 9'b000010000,  // free: exact start lookup
    P_UREM   = 9'b000100000,  // free: used entry removed
    P_FPOS   = 9'b001000000,  // free: insert slot and neighbors in free table
    P_FMERGE = 9'b010000000,  // free: merged both sides, right entry to drop
    P_FEND   = 9'b100000000
  } phase_t;

  typedef enum logic { T_FREE = 1'b0, T_USED = 1'b1 } tsel_t;

  state_t            state_r, state_nxt;
  phase_t            op_r, op_nxt;
  tsel_t             tsel_r, tsel_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     lim_r, lim_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     fc_r, fc_nxt;
  logic [CW-1:0]     uc_r, uc_nxt;
  logic              hit_r, hit_nxt;
  logic              lval_r, lval_nxt;
  logic [OB-1:0]     cs_r, cs_nxt;      // entry captured on hit
  logic [SW-1:0]     cz_r, cz_nxt;
  logic [OB-1:0]     ls_r, ls_nxt;      // last entry passed (left neighbor)
  logic [SW-1:0]     lz_r, lz_nxt;
  logic [OB-1:0]     s_r, s_nxt;        // chunk being moved
  logic [SW-1:0]     z_r, z_nxt;
  logic [OB-1:0]     ws_r, ws_nxt;      // entry for S_WRITE
  logic [SW-1:0]     wz_r, wz_nxt;
  logic [REQ_W-1:0]  bytes_r, bytes_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [ADDR_W-1:0] res_r, res_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [REQ_W-1:0]  hsize_r, hsize_nxt;
  logic              ov_r, ov_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;

  // table ports
  logic          f_we, u_we;
  logic [TW-1:0] f_rdata, u_rdata, m_wdata;
  logic [CW-1:0] m_waddr, m_raddr;
  logic          m_we, m_init;
  logic [TW-1:0] rd;
  logic [OB-1:0] rd_s;
  logic [SW-1:0] rd_z;

  // compare unit
  scan_kind_t kind;
  logic       alu_hit;

  // misc arithmetic
  logic [EW-1:0] eff_e, cap_e, hs_e, tail_e, nstart_e;
  logic [SW-1:0] eff_z;
  logic [SW:0]   l_end, m_end, sum_lz, sum_lzr, sum_zr;
  logic          merge_l, merge_r;
  logic          in_acc, cfg_acc, out_free;

  assign in_acc   = in_valid && !in_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign in_stall = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_free = !ov_r || !out_stall;

  assign out_valid          = ov_r;
  assign out_status         = ostat_r;
  assign out_result_address = oaddr_r;

  // effective heap size: heap_size clamped to 2^OB
  assign hs_e  = EW'(hsize_r);
  assign cap_e = EW'(1) << OB;
  assign eff_e = (hs_e > cap_e) ? cap_e : hs_e;
  assign eff_z = eff_e[SW-1:0];

  assign rd   = (tsel_r == T_USED) ? u_rdata : f_rdata;
  assign rd_s = rd[TW-1:SW];
  assign rd_z = rd[SW-1:0];

  assign tail_e   = EW'(cz_r) - EW'(bytes_r);
  assign nstart_e = EW'(cs_r) + EW'(bytes_r);

  // neighbor touch checks for a freed chunk
  assign l_end   = (SW+1)'(ls_r) + (SW+1)'(lz_r);
  assign m_end   = (SW+1)'(s_r) + (SW+1)'(z_r);
  assign merge_l = lval_r && (l_end == (SW+1)'(s_r));
  assign merge_r = hit_r && (m_end == (SW+1)'(cs_r));
  assign sum_lz  = (SW+1)'(lz_r) + (SW+1)'(z_r);
  assign sum_lzr = sum_lz + (SW+1)'(cz_r);
  assign sum_zr  = (SW+1)'(z_r) + (SW+1)'(cz_r);

  always_comb begin
    unique case (op_r)
      P_FIT:   kind = SK_FIT;
      P_MATCH: kind = SK_MATCH;
      default: kind = SK_AFTER;
    endcase
  end

  ffha_alu #(.OB(OB), .SW(SW), .EW(EW)) u_alu (
    .kind      (kind),
    .rd_start  (rd_s),
    .rd_size   (rd_z),
    .key_start (s_r),
    .req_bytes (bytes_r),
    .heap_base (base_r),
    .blk_addr  (addr_r),
    .hit       (alu_hit)
  );

  // table access per state
  always_comb begin
    m_we    = 1'b0;
    m_init  = 1'b0;
    m_waddr = idx_r;
    m_wdata = rd;
    m_raddr = idx_r;
    unique case (state_r)
      S_INIT: begin
        m_init  = 1'b1;
        m_waddr = '0;
        m_wdata = {{OB{1'b0}}, eff_z};
      end
      S_SHDN_RD: m_raddr = idx_r + CW'(1);
      S_SHUP_RD: m_raddr = idx_r - CW'(1);
      S_SHDN_WR, S_SHUP_WR: m_we = 1'b1;
      S_WRITE: begin
        m_we    = 1'b1;
        m_waddr = pos_r;
        m_wdata = {ws_r, wz_r};
      end
      default: m_we = 1'b0;
    endcase
  end

  assign f_we = m_init || (m_we && tsel_r == T_FREE);
  assign u_we = m_we && tsel_r == T_USED;

  ffha_tbl #(.DEPTH(MAX_ENTRIES), .W(TW)) u_free_tbl (
    .clk   (clk),
    .we    (f_we),
    .waddr (m_waddr[IW-1:0]),
    .wdata (m_wdata),
    .raddr (m_raddr[IW-1:0]),
    .rdata (f_rdata)
  );

  ffha_tbl #(.DEPTH(MAX_ENTRIES), .W(TW)) u_used_tbl (
    .clk   (clk),
    .we    (u_we),
    .waddr (m_waddr[IW-1:0]),
    .wdata (m_wdata),
    .raddr (m_raddr[IW-1:0]),
    .rdata (u_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    tsel_nxt  = tsel_r;
    idx_nxt   = idx_r;
    lim_nxt   = lim_r;
    pos_nxt   = pos_r;
    fc_nxt    = fc_r;
    uc_nxt    = uc_r;
    hit_nxt   = hit_r;
    lval_nxt  = lval_r;
    cs_nxt    = cs_r;
    cz_nxt    = cz_r;
    ls_nxt    = ls_r;
    lz_nxt    = lz_r;
    s_nxt     = s_r;
    z_nxt     = z_r;
    ws_nxt    = ws_r;
    wz_nxt    = wz_r;
    bytes_nxt = bytes_r;
    addr_nxt  = addr_r;
    stat_nxt  = stat_r;
    res_nxt   = res_r;
    base_nxt  = base_r;
    hsize_nxt = hsize_r;
    ov_nxt    = ov_r && out_stall;
    ostat_nxt = ostat_r;
    oaddr_nxt = oaddr_r;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          if (cfg_index == REG_HEAP_BASE) begin
            base_nxt = cfg_data;
          end else begin
            hsize_nxt = cfg_data[REQ_W-1:0];
            state_nxt = S_INIT;
          end
        end else if (in_acc) begin
          bytes_nxt = in_request_bytes;
          addr_nxt  = in_block_address;
          stat_nxt  = ST_OK;
          res_nxt   = '0;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          lval_nxt  = 1'b0;
          if (in_mode == MODE_ALLOC) begin
            op_nxt    = P_FIT;
            tsel_nxt  = T_FREE;
            lim_nxt   = fc_r;
            state_nxt = (in_request_bytes == '0) ? S_DONE : S_SCAN_RD;
          end else begin
            op_nxt    = P_MATCH;
            tsel_nxt  = T_USED;
            lim_nxt   = uc_r;
            state_nxt = (in_block_address == '0) ? S_DONE : S_SCAN_RD;
          end
        end
      end
      S_INIT: begin
        fc_nxt    = (eff_z != '0) ? CW'(1) : '0;
        uc_nxt    = '0;
        state_nxt = S_IDLE;
      end
      S_SCAN_RD: begin
        state_nxt = (idx_r == lim_r) ? S_NEXT : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (alu_hit) begin
          hit_nxt   = 1'b1;
          cs_nxt    = rd_s;
          cz_nxt    = rd_z;
          state_nxt = S_NEXT;
        end else begin
          lval_nxt  = 1'b1;
          ls_nxt    = rd_s;
          lz_nxt    = rd_z;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHDN_RD: begin
        state_nxt = ((idx_r + CW'(1)) >= lim_r) ? S_NEXT : S_SHDN_WR;
      end
      S_SHDN_WR: begin
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SHDN_RD;
      end
      S_SHUP_RD: begin
        state_nxt = (idx_r == pos_r) ? S_WRITE : S_SHUP_WR;
      end
      S_SHUP_WR: begin
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_SHUP_RD;
      end
      S_WRITE: begin
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        unique case (op_r)
          P_FIT: begin
            if (!hit_r) begin
              stat_nxt  = ST_OOM;
              state_nxt = S_DONE;
            end else if (uc_r == MAX_CNT) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              s_nxt   = cs_r;
              res_nxt = base_r + ADDR_W'(cs_r);
              pos_nxt = idx_r;
              op_nxt  = P_FUPD;
              if (tail_e != '0) begin
                // tail keeps the same slot
                ws_nxt    = nstart_e[OB-1:0];
                wz_nxt    = tail_e[SW-1:0];
                state_nxt = S_WRITE;
              end else begin
                lim_nxt   = fc_r;
                fc_nxt    = fc_r - CW'(1);
                state_nxt = S_SHDN_RD;
              end
            end
          end
          P_FUPD: begin
            tsel_nxt  = T_USED;
            op_nxt    = P_UPOS;
            idx_nxt   = '0;
            lim_nxt   = uc_r;
            hit_nxt   = 1'b0;
            lval_nxt  = 1'b0;
            state_nxt = S_SCAN_RD;
          end
          P_UPOS: begin
            pos_nxt   = idx_r;
            idx_nxt   = uc_r;
            ws_nxt    = s_r;
            wz_nxt    = SW'(bytes_r);
            uc_nxt    = uc_r + CW'(1);
            op_nxt    = P_UINS;
            state_nxt = S_SHUP_RD;
          end
          P_MATCH: begin
            if (!hit_r) begin
              stat_nxt  = ST_BADPTR;
              state_nxt = S_DONE;
            end else if (fc_r == MAX_CNT) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              s_nxt     = cs_r;
              z_nxt     = cz_r;
              lim_nxt   = uc_r;
              uc_nxt    = uc_r - CW'(1);
              op_nxt    = P_UREM;
              state_nxt = S_SHDN_RD;
            end
          end
          P_UREM: begin
            tsel_nxt  = T_FREE;
            op_nxt    = P_FPOS;
            idx_nxt   = '0;
            lim_nxt   = fc_r;
            hit_nxt   = 1'b0;
            lval_nxt  = 1'b0;
            state_nxt = S_SCAN_RD;
          end
          P_FPOS: begin
            // free table is kept coalesced, so only the two neighbors can touch
            priority if (merge_l && merge_r) begin
              ws_nxt    = ls_r;
              wz_nxt    = sum_lzr[SW-1:0];
              pos_nxt   = idx_r - CW'(1);
              op_nxt    = P_FMERGE;
              state_nxt = S_WRITE;
            end else if (merge_l) begin
              ws_nxt    = ls_r;
              wz_nxt    = sum_lz[SW-1:0];
              pos_nxt   = idx_r - CW'(1);
              op_nxt    = P_FEND;
              state_nxt = S_WRITE;
            end else if (merge_r) begin
              ws_nxt    = s_r;
              wz_nxt    = sum_zr[SW-1:0];
              pos_nxt   = idx_r;
              op_nxt    = P_FEND;
              state_nxt = S_WRITE;
            end else begin
              ws_nxt    = s_r;
              wz_nxt    = z_r;
              pos_nxt   = idx_r;
              idx_nxt   = fc_r;
              fc_nxt    = fc_r + CW'(1);
              op_nxt    = P_FEND;
              state_nxt = S_SHUP_RD;
            end
          end
          P_FMERGE: begin
            // drop the absorbed right neighbor
            idx_nxt   = pos_r + CW'(1);
            lim_nxt   = fc_r;
            fc_nxt    = fc_r - CW'(1);
            op_nxt    = P_FEND;
            state_nxt = S_SHDN_RD;
          end
          default: state_nxt = S_DONE;  // P_UINS, P_FEND
        endcase
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ostat_nxt = stat_r;
          oaddr_nxt = (stat_r == ST_OK) ? res_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      op_r    <= P_FEND;
      tsel_r  <= T_FREE;
      idx_r   <= '0;
      lim_r   <= '0;
      pos_r   <= '0;
      fc_r    <= '0;
      uc_r    <= '0;
      hit_r   <= 1'b0;
      lval_r  <= 1'b0;
      base_r  <= '0;
      hsize_r <= HEAP_SIZE_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      tsel_r  <= tsel_nxt;
      idx_r   <= idx_nxt;
      lim_r   <= lim_nxt;
      pos_r   <= pos_nxt;
      fc_r    <= fc_nxt;
      uc_r    <= uc_nxt;
      hit_r   <= hit_nxt;
      lval_r  <= lval_nxt;
      base_r  <= base_nxt;
      hsize_r <= hsize_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cs_r    <= cs_nxt;
    cz_r    <= cz_nxt;
    ls_r    <= ls_nxt;
    lz_r    <= lz_nxt;
    s_r     <= s_nxt;
    z_r     <= z_nxt;
    ws_r    <= ws_nxt;
    wz_r    <= wz_nxt;
    bytes_r <= bytes_nxt;
    addr_r  <= addr_nxt;
    stat_r  <= stat_nxt;
    res_r   <= res_nxt;
    ostat_r <= ostat_nxt;
    oaddr_r <= oaddr_nxt;
  end

`ifndef SYNTHESIS
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n) fc_r <= MAX_CNT)
    else $error("free count over capacity");
  a_uc_bound: assert property (@(posedge clk) disable iff (!rst_n) uc_r <= MAX_CNT)
    else $error("used count over capacity");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("item accepted but sequencer stayed idle");
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    m_we |-> m_waddr < MAX_CNT)
    else $error("table write beyond depth");
`endif

endmodule
`default_nettype wire

FILE: design/ffha_tbl.sv
`default_nettype none
module ffha_tbl #(
  parameter int DEPTH = 32,
  parameter int W     = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/ffha_alu.sv
`default_nettype none
module ffha_alu
  import ffha_pkg::*;
#(
  parameter int OB = 16,
  parameter int SW = 17,
  parameter int EW = 17
) (
  input  scan_kind_t         kind,
  input  logic [OB-1:0]      rd_start,
  input  logic [SW-1:0]      rd_size,
  input  logic [OB-1:0]      key_start,
  input  logic [REQ_W-1:0]   req_bytes,
  input  logic [ADDR_W-1:0]  heap_base,
  input  logic [ADDR_W-1:0]  blk_addr,
  output logic               hit
);

  logic [ADDR_W-1:0] abs_addr;

  assign abs_addr = heap_base + ADDR_W'(rd_start);

  always_comb begin
    unique case (kind)
      SK_FIT:   hit = EW'(rd_size) >= EW'(req_bytes);
      SK_MATCH: hit = abs_addr == blk_addr;
      SK_AFTER: hit = rd_start > key_start;
      default:  hit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

import ffha_pkg::*;

// Mirror of the allocator: free and used chunk tables, predicts one result per request.
class alloc_scoreboard;
  localparam int NENT = 32;
  localparam int CAP = 65536;

  bit [31:0] base_addr;
  bit [16:0] heap_bytes;
  int unsigned fr_st[NENT], fr_sz[NENT], us_st[NENT], us_sz[NENT];
  int unsigned fr_n, us_n;
  logic [STAT_W-1:0] exp_status[$];
  logic [ADDR_W-1:0] exp_addr[$];
  bit [31:0] live_ptrs[$];
  int errors;

  function void init_tables();
    int unsigned eff;
    eff = (heap_bytes > CAP) ? CAP : heap_bytes;
    foreach (fr_st[i]) begin
      fr_st[i] = 0; fr_sz[i] = 0; us_st[i] = 0; us_sz[i] = 0;
    end
    us_n = 0;
    fr_sz[0] = eff;
    fr_n = (eff != 0);
    live_ptrs.delete();
  endfunction

  function void set_reg(bit idx, bit [31:0] val);
    if (idx == REG_HEAP_BASE) base_addr = val;
    else begin
      heap_bytes = val[16:0];
      init_tables();
    end
  endfunction

  function void drop(ref int unsigned st[NENT], ref int unsigned sz[NENT],
                     ref int unsigned n, input int unsigned pos);
    for (int unsigned i = pos; i + 1 < n; i++) begin
      st[i] = st[i+1]; sz[i] = sz[i+1];
    end
    n--;
    st[n] = 0; sz[n] = 0;
  endfunction

  function void place(ref int unsigned st[NENT], ref int unsigned sz[NENT],
                      ref int unsigned n, input int unsigned s, input int unsigned z);
    int unsigned p;
    if (z == 0 || n >= NENT) return;
    p = n;
    while (p > 0 && st[p-1] > s) begin
      st[p] = st[p-1]; sz[p] = sz[p-1]; p--;
    end
    st[p] = s; sz[p] = z; n++;
  endfunction

  // note an accepted request item and queue its expected result
  function void note_request(bit mode, bit [16:0] bytes, bit [31:0] addr);
    logic [STAT_W-1:0] st;
    bit [31:0] res;
    int unsigned i, s, z;
    bit hit;
    st = ST_OK; res = 0; hit = 0;
    if (mode == MODE_ALLOC) begin
      if (bytes != 0) begin
        for (i = 0; i < fr_n; i++) if (fr_sz[i] >= bytes) begin hit = 1; break; end
        if (!hit) st = ST_OOM;
        else if (us_n >= NENT) st = ST_FULL;
        else begin
          s = fr_st[i]; z = fr_sz[i] - bytes;
          drop(fr_st, fr_sz, fr_n, i);
          place(us_st, us_sz, us_n, s, bytes);
          place(fr_st, fr_sz, fr_n, s + bytes, z);
          res = base_addr + s;
          live_ptrs.push_back(res);
        end
      end
    end else if (addr != 0) begin
      for (i = 0; i < us_n; i++) if (base_addr + us_st[i] == addr) begin hit = 1; break; end
      if (!hit) st = ST_BADPTR;
      else if (fr_n >= NENT) st = ST_FULL;
      else begin
        s = us_st[i]; z = us_sz[i];
        drop(us_st, us_sz, us_n, i);
        place(fr_st, fr_sz, fr_n, s, z);
        i = 0;
        while (i + 1 < fr_n) begin
          if (fr_st[i] + fr_sz[i] == fr_st[i+1]) begin
            fr_sz[i] += fr_sz[i+1];
            drop(fr_st, fr_sz, fr_n, i + 1);
          end else i++;
        end
        foreach (live_ptrs[k]) if (live_ptrs[k] == addr) begin
          live_ptrs.delete(k); break;
        end
      end
    end
    exp_status.push_back(st);
    exp_addr.push_back(res);
  endfunction

  task report(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  task check_result(logic [STAT_W-1:0] st, logic [ADDR_W-1:0] ad);
    if (exp_status.size() == 0) begin
      report($sformatf("unexpected result status=%0d addr=%h", st, ad));
      return;
    end
    if (st !== exp_status[0])
      report($sformatf("status got %0d want %0d", st, exp_status[0]));
    if (ad !== exp_addr[0])
      report($sformatf("address got %h want %h", ad, exp_addr[0]));
    void'(exp_status.pop_front());
    void'(exp_addr.pop_front());
  endtask
endclass

module testbench;
  import ffha_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_mode = 0;
  logic [REQ_W-1:0] in_request_bytes = 0;
  logic [ADDR_W-1:0] in_block_address = 0;
  logic in_stall, out_valid;
  logic out_stall = 0;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_result_address;
  logic cfg_valid = 0, cfg_index = 0;
  logic [ADDR_W-1:0] cfg_data = 0;
  logic cfg_ready;

  alloc_scoreboard heap_sb;
  bit long_hold = 0;        // receiver holds off entirely while set
  int unsigned cycle_cnt = 0;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  always #6 clk = ~clk;

  first_fit_heap_allocator_unit u_dut (.*);

  // scoreboard check at the rising edge
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      heap_sb.check_result(out_status, out_result_address);

  // receiver stall: mostly short random gaps, some long, plus a forced hold
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold) out_stall <= 1;
      else begin
        n = $urandom_range(0, 99);
        if (n < 55) out_stall <= 0;
        else if (n < 97) out_stall <= 1;
        else begin
          out_stall <= 1;
          repeat ($urandom_range(20, 150)) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(bit idx, bit [31:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    heap_sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // offer one item; valid held across back-to-back items
  task automatic send_item(bit mode, bit [16:0] bytes, bit [31:0] addr);
    in_valid <= 1; in_mode <= mode; in_request_bytes <= bytes; in_block_address <= addr;
    do @(posedge clk); while (in_stall);
    heap_sb.note_request(mode, bytes, addr);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      in_request_bytes <= 17'($urandom);
      in_block_address <= $urandom;
      in_mode <= 1'($urandom);
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 80) : $urandom_range(1, 3))
        @(negedge clk);
    end
  endtask

  // wait until every result is back, then idle before the next phase
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (heap_sb.exp_status.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // random item: mostly frees of live blocks and small allocs, some noise
  task automatic random_item(int unsigned big);
    int n;
    bit [31:0] a;
    n = $urandom_range(0, 99);
    if (n < 45) send_item(MODE_ALLOC, 17'($urandom_range(1, big)), $urandom);
    else if (n < 80 && heap_sb.live_ptrs.size() != 0) begin
      a = heap_sb.live_ptrs[$urandom_range(0, heap_sb.live_ptrs.size() - 1)];
      send_item(MODE_FREE, 17'($urandom), a);
    end else if (n < 88) send_item(MODE_ALLOC, 17'($urandom), $urandom);
    else if (n < 93) send_item(MODE_ALLOC, 0, $urandom);
    else if (n < 96) send_item(MODE_FREE, 17'($urandom), 0);
    else send_item(MODE_FREE, 17'($urandom), $urandom);
  endtask

  initial begin
    heap_sb = new();
    heap_sb.errors = 0;
    heap_sb.set_reg(REG_HEAP_BASE, 0);
    heap_sb.set_reg(REG_HEAP_SIZE, HEAP_SIZE_RST);
    repeat (9) @(negedge clk);
    rst_n <= 1;
    repeat (3) @(negedge clk);

    // directed: reset heap, extremes, zero size, null/bad free, full used table
    send_item(MODE_ALLOC, 17'd65536, 0);
    send_item(MODE_ALLOC, 17'd1, 0);
    send_item(MODE_ALLOC, 17'h1FFFF, 0);
    send_item(MODE_ALLOC, 0, 32'hFFFF_FFFF);
    send_item(MODE_FREE, 0, 0);
    send_item(MODE_FREE, 17'h1FFFF, 32'hFFFF_FFFF);
    send_item(MODE_FREE, 0, 32'd0 + 0);
    drain();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);   // wraps past 2^32
    write_reg(REG_HEAP_SIZE, 17'd40);
    for (int i = 0; i < 34; i++) send_item(MODE_ALLOC, 17'd1, 0);  // fills used table
    send_item(MODE_FREE, 0, 32'hFFFF_FFF0 + 5);
    send_item(MODE_FREE, 0, 32'hFFFF_FFF0 + 5);
    send_item(MODE_FREE, 0, 32'hFFFF_FFF0 + 7);
    send_item(MODE_FREE, 0, 32'hFFFF_FFF0 + 6);
    drain();
    write_reg(REG_HEAP_SIZE, 0);
    send_item(MODE_ALLOC, 17'd1, 0);
    send_item(MODE_ALLOC, 0, 0);
    drain();

    // random phases with varying heap settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned big;
      case (ph)
        0: begin write_reg(REG_HEAP_BASE, 0); write_reg(REG_HEAP_SIZE, 17'h1FFFF); end
        1: begin write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF); write_reg(REG_HEAP_SIZE, 17'd1); end
        2: begin write_reg(REG_HEAP_BASE, $urandom); write_reg(REG_HEAP_SIZE, 17'd65536); end
        default: begin
          write_reg(REG_HEAP_BASE, $urandom);
          write_reg(REG_HEAP_SIZE, $urandom_range(16, 4096));
        end
      endcase
      big = (heap_sb.heap_bytes > 64) ? heap_sb.heap_bytes / 24 : 4;
      if (ph == 2) long_hold = 1;        // receiver goes quiet, input backs up
      for (int k = 0; k < 200; k++) begin
        // hold length counted on its own, since the sender blocks once the block is full
        if (ph == 2 && k == 0) fork
          begin repeat (600) @(negedge clk); long_hold = 0; end
        join_none
        random_item(big);
      end
      drain();
    end

    if (heap_sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

`default_nettype wire

FILE: files.f
design/ffha_pkg.sv
design/ffha_tbl.sv
design/ffha_alu.sv
design/first_fit_heap_allocator_unit.sv
tb/testbench.sv
